FILE: hw/rtl/knni_pkg.sv
// shared types and constants for the k-nearest-neighbour insertion block
// no dependencies; imported by knni_dist_sq, k_nearest_neighbour_insert, knn_list_checker and the testbench
package knni_pkg;

  localparam int unsigned MaxKeptDefault = 16;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned IdW      = 16;
  localparam int unsigned DistW    = 33;
  localparam int unsigned CountW   = 5;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 33;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 88;

  localparam logic [CountW-1:0] MaxNeighboursReset = 5'd10;
  localparam logic [DistW-1:0]  SearchRangeReset   = 33'd225;

  typedef enum logic [ReqW-1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_OFFER  = 2'd1,
    REQ_FINISH = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_NEIGHBOURS = 1'b0,
    CFG_SEARCH_RANGE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_CHECK,
    ST_RD,
    ST_CMP,
    ST_PLACE,
    ST_RREAD,
    ST_RSET,
    ST_RESP,
    ST_ERD,
    ST_EOUT
  } knn_state_e;

  typedef enum logic [1:0] {
    DSQ_IDLE,
    DSQ_SQ_X,
    DSQ_SQ_Y,
    DSQ_SUM
  } dsq_phase_e;

  typedef struct packed {
    logic                     start;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } dsq_req_t;

  typedef struct packed {
    logic             done;
    logic [DistW-1:0] dist_sq;
  } dsq_rsp_t;

endpackage

FILE: hw/rtl/knni_dist_sq.sv
// squared distance unit: one shared 17x17 multiplier used for dx then dy
// depends on knni_pkg
module knni_dist_sq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  knni_pkg::dsq_req_t req_i,
  output knni_pkg::dsq_rsp_t rsp_o
);
  import knni_pkg::*;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned SqW   = 2 * CoordW;

  dsq_phase_e phase_q, phase_d;
  logic done_q;

  logic signed [DiffW-1:0]   dx_q, dy_q;
  logic signed [DiffW-1:0]   mul_op;
  logic signed [2*DiffW-1:0] mul_prod;
  logic [SqW-1:0]            sq_x_q, sq_y_q;
  logic [DistW-1:0]          dist_q;

  // one multiplier, operand picked by phase
  assign mul_op   = (phase_q == DSQ_SQ_Y) ? dy_q : dx_q;
  assign mul_prod = mul_op * mul_op;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      DSQ_IDLE: if (req_i.start) phase_d = DSQ_SQ_X;
      DSQ_SQ_X: phase_d = DSQ_SQ_Y;
      DSQ_SQ_Y: phase_d = DSQ_SUM;
      DSQ_SUM:  phase_d = DSQ_IDLE;
      default:  phase_d = DSQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DSQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == DSQ_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == DSQ_IDLE && req_i.start) begin
      dx_q <= DiffW'(req_i.qx) - DiffW'(req_i.cx);
      dy_q <= DiffW'(req_i.qy) - DiffW'(req_i.cy);
    end
    // squares of 17-bit differences stay below 2^32
    if (phase_q == DSQ_SQ_X) sq_x_q <= mul_prod[SqW-1:0];
    if (phase_q == DSQ_SQ_Y) sq_y_q <= mul_prod[SqW-1:0];
    if (phase_q == DSQ_SUM)  dist_q <= DistW'(sq_x_q) + DistW'(sq_y_q);
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.dist_sq = dist_q;

endmodule

FILE: hw/rtl/k_nearest_neighbour_insert.sv
// k-nearest-neighbour list with ordered insertion, top level
// depends on knni_pkg and knni_dist_sq
//
// channel   dir  handshake                  contents
// s_axis    in   s_axis_tvalid/tready        request: kind in tuser, point and id in tdata
// m_axis    out  m_axis_tvalid/tready        status or list entry, tlast on final one
// cfg       in   cfg_we_i (no wait)          capacity / initial search range
//
// a begin or an offer with the query id gives one status result; a finish
// emits each kept entry in turn, or a status result when the list is empty;
// any other offer runs the distance unit and the range check and, if kept,
// list compares (at most one more than the entries shifted down), the place
// write and, if the list is full, a range reload; the distance unit has one
// shared multiplier; a compare reads the list memory and writes on a shift
// reset clears query state, count and range; the list memory is not cleared
// input is not ready until the last result of the current request is taken
module k_nearest_neighbour_insert #(
  parameter int unsigned MAX_KEPT = knni_pkg::MaxKeptDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [knni_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [knni_pkg::CfgDataW-1:0] cfg_data_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [knni_pkg::InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y, agent_id
  input  logic [knni_pkg::ReqW-1:0]     s_axis_tuser,  // req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [knni_pkg::OutDataW-1:0] m_axis_tdata,  // entry_id, entry_dist_sq,
                                                       // kept_count, range_now, pad
  output logic                          m_axis_tlast   // last
);
  import knni_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned IdxW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CapW  = (CntW > CountW) ? CntW : CountW;
  localparam int unsigned EntW  = DistW + IdW;
  localparam int unsigned PadW  = OutDataW - (IdW + DistW + CountW + DistW);
  localparam logic [CapW-1:0] MaxKeptC = CapW'(MAX_KEPT);

  // request fields
  req_type_e                req_type;
  logic signed [CoordW-1:0] in_x, in_y;
  logic [IdW-1:0]           in_id;

  assign req_type = req_type_e'(s_axis_tuser);
  assign in_x     = s_axis_tdata[CoordW-1:0];
  assign in_y     = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_id    = s_axis_tdata[2*CoordW+IdW-1:2*CoordW];

  // control state
  knn_state_e state_q, state_d;
  logic [CountW-1:0]        max_nb_q;
  logic [DistW-1:0]         search_q;
  logic signed [CoordW-1:0] query_x_q, query_y_q;
  logic [IdW-1:0]           query_id_q;
  logic [DistW-1:0]         range_q;
  logic [CntW-1:0]          count_q;
  logic [IdxW-1:0]          idx_q;   // insertion slot while shifting
  logic [IdxW-1:0]          k_q;     // emit position

  // payload
  logic [IdW-1:0] cand_id_q;
  logic [EntW-1:0] rd_q;
  logic [DistW-1:0] rd_dist;
  logic [IdW-1:0]   rd_id;

  // list memory, one write and one registered read per cycle
  logic [EntW-1:0] list_mem [MAX_KEPT];
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata;

  dsq_req_t dsq_req;
  dsq_rsp_t dsq_rsp;

  // derived control
  logic [CapW-1:0] mn_ext;
  logic [CntW-1:0] cap;
  logic [CntW-1:0] new_count;
  logic            take, shift, emit_last, cand_same;

  assign rd_dist = rd_q[EntW-1:IdW];
  assign rd_id   = rd_q[IdW-1:0];

  // capacity saturates at the storage depth
  assign mn_ext    = CapW'(max_nb_q);
  assign cap       = (mn_ext > MaxKeptC) ? CntW'(MaxKeptC) : CntW'(mn_ext);
  assign new_count = (count_q < cap) ? count_q + 1'b1 : count_q;
  // strictly inside the range and room for at least one entry
  assign take      = (dsq_rsp.dist_sq < range_q) && (new_count != '0);
  assign shift     = (dsq_rsp.dist_sq < rd_dist);
  assign emit_last = ((CntW'(k_q) + 1'b1) == count_q);
  assign cand_same = (in_id == query_id_q);

  knni_dist_sq u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dsq_req),
    .rsp_o  (dsq_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (req_type)
            REQ_BEGIN:  state_d = ST_RESP;
            REQ_OFFER:  state_d = cand_same ? ST_RESP : ST_DIST;
            REQ_FINISH: state_d = (count_q != '0) ? ST_ERD : ST_RESP;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_DIST:  if (dsq_rsp.done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!take)                    state_d = ST_RESP;
        else if (new_count == CntW'(1)) state_d = ST_PLACE;
        else                          state_d = ST_RD;
      end
      ST_RD:    state_d = ST_CMP;
      ST_CMP: begin
        if (shift && idx_q != IdxW'(1)) state_d = ST_RD;
        else                          state_d = ST_PLACE;
      end
      ST_PLACE: state_d = (count_q == cap) ? ST_RREAD : ST_RESP;
      ST_RREAD: state_d = ST_RSET;
      ST_RSET:  state_d = ST_RESP;
      ST_RESP:  if (m_axis_tready) state_d = ST_IDLE;
      ST_ERD:   state_d = ST_EOUT;
      ST_EOUT: begin
        if (m_axis_tready) state_d = emit_last ? ST_IDLE : ST_ERD;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_RESP) || (state_q == ST_EOUT);

    dsq_req.start = (state_q == ST_IDLE) && s_axis_tvalid &&
                    (req_type == REQ_OFFER) && !cand_same;
    dsq_req.qx    = query_x_q;
    dsq_req.qy    = query_y_q;
    dsq_req.cx    = in_x;
    dsq_req.cy    = in_y;

    mem_re    = 1'b0;
    mem_raddr = k_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_q;
    unique case (state_q)
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q - 1'b1;
      end
      ST_CMP: begin
        // move the neighbour above down one slot
        mem_we = shift;
      end
      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_wdata = {dsq_rsp.dist_sq, cand_id_q};
      end
      ST_RREAD: begin
        // worst kept entry becomes the new range
        mem_re    = 1'b1;
        mem_raddr = IdxW'(count_q - 1'b1);
      end
      ST_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
      end
      default: ;
    endcase
  end

  // result fields: entry fields are zero on a status result
  always_comb begin
    if (state_q == ST_EOUT) begin
      m_axis_tdata = {PadW'(0), range_q, CountW'(count_q), rd_dist, rd_id};
      m_axis_tlast = emit_last;
    end else begin
      m_axis_tdata = {PadW'(0), range_q, CountW'(count_q), DistW'(0), IdW'(0)};
      m_axis_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      max_nb_q   <= MaxNeighboursReset;
      search_q   <= SearchRangeReset;
      query_x_q  <= '0;
      query_y_q  <= '0;
      query_id_q <= '0;
      range_q    <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_NEIGHBOURS: max_nb_q <= cfg_data_i[CountW-1:0];
          CFG_SEARCH_RANGE:   search_q <= cfg_data_i[DistW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && req_type == REQ_BEGIN) begin
            query_x_q  <= in_x;
            query_y_q  <= in_y;
            query_id_q <= in_id;
            count_q    <= '0;
            range_q    <= search_q;
          end
          if (s_axis_tvalid && req_type == REQ_FINISH) k_q <= '0;
        end
        ST_CHECK: begin
          if (take) begin
            count_q <= new_count;
            idx_q   <= IdxW'(new_count - 1'b1);
          end
        end
        ST_CMP:  if (shift) idx_q <= idx_q - 1'b1;
        ST_RSET: range_q <= rd_dist;
        ST_EOUT: if (m_axis_tready && !emit_last) k_q <= k_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) cand_id_q <= in_id;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) list_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= list_mem[mem_raddr];
  end

endmodule

FILE: test/knn_list_checker.sv
// result checker for k_nearest_neighbour_insert: mirrors the sorted neighbour list
// depends on knni_pkg; watches the config port and both streams of the block
`timescale 1ns / 1ps

module knn_list_checker #(
  parameter int unsigned MaxKept = knni_pkg::MaxKeptDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knni_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [knni_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [knni_pkg::InDataW-1:0]  s_axis_tdata,  // pos_x, pos_y, agent_id
  input  logic [knni_pkg::ReqW-1:0]     s_axis_tuser,  // req_type
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [knni_pkg::OutDataW-1:0] m_axis_tdata,  // entry_id, entry_dist_sq,
                                                       // kept_count, range_now, pad
  input  logic                          m_axis_tlast,  // last
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import knni_pkg::*;

  localparam int unsigned DistLo      = IdW;
  localparam int unsigned CountLo     = IdW + DistW;
  localparam int unsigned RangeLo     = IdW + DistW + CountW;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [IdW-1:0]    entry_id;
    logic [DistW-1:0]  entry_dist;
    logic [CountW-1:0] kept_count;
    logic [DistW-1:0]  range_now;
    logic              last;
  } list_result_t;

  logic [CountW-1:0] capacity_cfg;
  logic [DistW-1:0]  start_range_cfg;
  logic [CoordW-1:0] query_x;
  logic [CoordW-1:0] query_y;
  logic [IdW-1:0]    query_id;
  logic [DistW:0]    range_sq;
  int unsigned       kept;
  logic [DistW:0]    kept_dist [MaxKept];
  logic [IdW-1:0]    kept_id   [MaxKept];
  list_result_t      expected_q [$];
  int unsigned       fails;

  function automatic list_result_t make_result(input logic [IdW-1:0] id,
                                               input logic [DistW-1:0] dist_val,
                                               input logic last);
    list_result_t res;
    res.entry_id   = id;
    res.entry_dist = dist_val;
    res.kept_count = CountW'(kept);
    res.range_now  = range_sq[DistW-1:0];
    res.last       = last;
    return res;
  endfunction

  // append one predicted result at the tail of the queue
  function automatic void queue_result(input list_result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic list_result_t unpack_result(input logic [OutDataW-1:0] data,
                                                 input logic last);
    list_result_t res;
    res.entry_id   = data[0 +: IdW];
    res.entry_dist = data[DistLo +: DistW];
    res.kept_count = data[CountLo +: CountW];
    res.range_now  = data[RangeLo +: DistW];
    res.last       = last;
    return res;
  endfunction

  function automatic string describe(input list_result_t r);
    return $sformatf("id %0d dist %0d count %0d range %0d last %0b",
                     r.entry_id, r.entry_dist, r.kept_count, r.range_now, r.last);
  endfunction

  // exact: each difference fits 17 bits signed
  function automatic logic [DistW:0] squared_distance(input logic [CoordW-1:0] px,
                                                      input logic [CoordW-1:0] py);
    longint dx;
    longint dy;
    dx = longint'($signed(query_x)) - longint'($signed(px));
    dy = longint'($signed(query_y)) - longint'($signed(py));
    return (DistW+1)'(dx * dx + dy * dy);
  endfunction

  task automatic offer_candidate(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                                 input logic [IdW-1:0] cid);
    int unsigned    cap;
    logic [DistW:0] d;
    int unsigned    i;
    cap = 32'(capacity_cfg);
    if (cap > MaxKept) cap = MaxKept;
    if (cid == query_id) return;
    d = squared_distance(px, py);
    if (d >= range_sq) return;
    if (kept < cap) kept++;
    if (kept == 0 || kept > MaxKept) return;
    // shift worse entries down, dropping the old worst when the list did not grow
    i = kept - 1;
    while (i != 0 && d < kept_dist[i-1]) begin
      kept_dist[i] = kept_dist[i-1];
      kept_id[i]   = kept_id[i-1];
      i--;
    end
    kept_dist[i] = d;
    kept_id[i]   = cid;
    if (kept == cap) range_sq = kept_dist[kept-1];
  endtask

  task automatic apply_request(input logic [ReqW-1:0] req, input logic [InDataW-1:0] data);
    int unsigned n;
    case (req)
      REQ_BEGIN: begin
        query_x  = data[0 +: CoordW];
        query_y  = data[CoordW +: CoordW];
        query_id = data[2*CoordW +: IdW];
        kept     = 0;
        range_sq = {1'b0, start_range_cfg};
        queue_result(make_result('0, '0, 1'b1));
      end
      REQ_OFFER: begin
        offer_candidate(data[0 +: CoordW], data[CoordW +: CoordW], data[2*CoordW +: IdW]);
        queue_result(make_result('0, '0, 1'b1));
      end
      REQ_FINISH: begin
        n = (kept > MaxKept) ? MaxKept : kept;
        if (n == 0) begin
          queue_result(make_result('0, '0, 1'b1));
        end else begin
          for (int k = 0; k < int'(n); k++) begin
            queue_result(make_result(kept_id[k], kept_dist[k][DistW-1:0],
                                     k == int'(n) - 1));
          end
        end
      end
      default: begin
        queue_result(make_result('0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_result(input list_result_t got);
    list_result_t want;
    if (expected_q.size() == 0) begin
      fails++;
      if (fails <= ReportLimit) $display("%0t: unexpected result: %s", $time, describe(got));
      return;
    end
    want = expected_q.pop_front();
    if (got.entry_id !== want.entry_id || got.entry_dist !== want.entry_dist ||
        got.kept_count !== want.kept_count || got.range_now !== want.range_now ||
        got.last !== want.last) begin
      fails++;
      if (fails <= ReportLimit) begin
        $display("%0t: result mismatch, expected %s", $time, describe(want));
        $display("%0t:                  actual   %s", $time, describe(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_cfg    = MaxNeighboursReset;
      start_range_cfg = SearchRangeReset;
      query_x         = '0;
      query_y         = '0;
      query_id        = '0;
      range_sq        = '0;
      kept            = 0;
      for (int k = 0; k < int'(MaxKept); k++) begin
        kept_dist[k] = '0;
        kept_id[k]   = '0;
      end
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(unpack_result(m_axis_tdata, m_axis_tlast));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_NEIGHBOURS: capacity_cfg    = cfg_data_i[CountW-1:0];
          CFG_SEARCH_RANGE:   start_range_cfg = cfg_data_i[DistW-1:0];
          default:            ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser, s_axis_tdata);
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

FILE: test/k_nearest_neighbour_insert_tb.sv
// testbench top for k_nearest_neighbour_insert: stimulus, backpressure and verdict
// depends on knni_pkg, k_nearest_neighbour_insert and knn_list_checker
`timescale 1ns / 1ps

module k_nearest_neighbour_insert_tb;
  import knni_pkg::*;

  localparam int unsigned    ResetCycles   = 6;
  localparam int unsigned    ItemTarget    = 500;
  localparam int unsigned    QuietItems    = 420;   // no idling past this many requests
  localparam int unsigned    LongHold      = 300;   // one long receiver stall
  localparam int unsigned    WatchdogLimit = 5000;
  localparam int unsigned    TailCycles    = 60;    // margin after the slowest offer
  localparam logic [ReqW-1:0]  ReqUnused   = 2'd3;  // not decoded, block just answers status
  localparam logic [DistW-1:0] DistMax     = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // pos_x, pos_y, agent_id
  logic [ReqW-1:0]     s_axis_tuser;   // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // entry_id, entry_dist_sq, kept_count, range_now, pad
  logic                m_axis_tlast;   // last

  int unsigned fail_count;
  int unsigned results_pending;

  // traffic control shared by the sender, the receiver and the watchdog
  bit          idle_on;
  bit          hold_long;
  int unsigned requests_sent;
  int unsigned quiet_cycles;

  // current query, kept so a later phase can go on offering to it
  logic [CoordW-1:0] query_x;
  logic [CoordW-1:0] query_y;
  logic [IdW-1:0]    query_id;

  k_nearest_neighbour_insert #(
    .MAX_KEPT(MaxKeptDefault)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  knn_list_checker #(
    .MaxKept(MaxKeptDefault)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall bursts while idling is on, one long hold on request
  initial begin
    forever begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (idle_on && requests_sent < QuietItems && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog: too long without any handshake on either stream ends the run
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // one request, with an optional idle burst in front; returns at the accepting edge
  task automatic send_request(input logic [ReqW-1:0] req, input logic [CoordW-1:0] px,
                              input logic [CoordW-1:0] py, input logic [IdW-1:0] id);
    if (idle_on && requests_sent < QuietItems && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {id, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (req != ReqUnused) requests_sent++;
  endtask

  // block goes idle once the last predicted result is taken
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // both registers in back-to-back cycles, only while idle
  task automatic load_settings(input logic [CountW-1:0] cap, input logic [DistW-1:0] range_sq);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAX_NEIGHBOURS;
    cfg_data <= CfgDataW'(cap);
    @(posedge clk_i);
    cfg_idx  <= CFG_SEARCH_RANGE;
    cfg_data <= range_sq;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] near(input logic [CoordW-1:0] c, input int spread);
    return c + CoordW'($urandom_range(0, 2 * spread)) - CoordW'(spread);
  endfunction

  // mostly normal sizes, sometimes zero or above the list depth
  function automatic logic [CountW-1:0] pick_capacity();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return CountW'($urandom_range(MaxKeptDefault + 1, 31));
    if (r < 5) return CountW'(MaxKeptDefault);
    return CountW'($urandom_range(1, MaxKeptDefault));
  endfunction

  // ranges matched to the candidate spreads so lists fill, plus the extremes
  function automatic logic [DistW-1:0] pick_range();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return DistMax;
    if (r < 5) return DistW'({$urandom, $urandom});
    if (r < 8) return DistW'($urandom_range(8000, 10000000));
    return DistW'($urandom_range(1000, 8000));
  endfunction

  // offers around the current query, with some noise mixed in
  task automatic offer_burst(input int n, input int spread);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 84) begin
        send_request(REQ_OFFER, near(query_x, spread), near(query_y, spread), IdW'($urandom));
      end else if (r < 90) begin
        // same id as the query, must be skipped
        send_request(REQ_OFFER, near(query_x, spread), near(query_y, spread), query_id);
      end else if (r < 96) begin
        send_request(REQ_OFFER, CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
      end else if (r < 98) begin
        send_request(REQ_FINISH, CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
      end else begin
        send_request(ReqUnused, CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
      end
    end
  endtask

  // begin, a stream of candidates, then usually a finish
  task automatic run_query();
    int r;
    int spread;
    query_x  = CoordW'($urandom);
    query_y  = CoordW'($urandom);
    query_id = IdW'($urandom);
    r = $urandom_range(0, 9);
    spread = (r < 4) ? 20 : (r < 8) ? 60 : 2000;
    send_request(REQ_BEGIN, query_x, query_y, query_id);
    offer_burst($urandom_range(0, 24), spread);
    // sometimes left open so the next phase changes settings mid-query
    if ($urandom_range(0, 9) != 0)
      send_request(REQ_FINISH, CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
  endtask

  initial begin
    int unsigned phase;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_MAX_NEIGHBOURS;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= REQ_BEGIN;
    s_axis_tdata  <= '0;
    idle_on       = 1'b0;
    hold_long     = 1'b0;
    requests_sent = 0;
    query_x       = '0;
    query_y       = '0;
    query_id      = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings (capacity 10, range 225)
    // offer before any begin sees the zero query and zero range
    send_request(REQ_OFFER, 16'd3, 16'd4, 16'd5);
    send_request(REQ_FINISH, 16'd0, 16'd0, 16'd0);       // empty list
    send_request(ReqUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(REQ_BEGIN, 16'd0, 16'd0, 16'd7);
    send_request(REQ_OFFER, 16'd1, 16'd1, 16'd7);        // same id as the query
    send_request(REQ_OFFER, 16'd9, 16'd12, 16'd1);       // distance equals range
    send_request(REQ_OFFER, 16'd9, 16'd11, 16'd1);
    send_request(REQ_OFFER, -16'sd3, 16'd4, 16'd2);      // goes in front
    send_request(REQ_OFFER, 16'd0, 16'd0, 16'd3);        // zero distance
    send_request(REQ_FINISH, 16'd0, 16'd0, 16'd0);

    // capacity lowered below the count of the open query
    wait_for_results();
    load_settings(5'd2, DistMax);
    send_request(REQ_OFFER, 16'd1, 16'd0, 16'd4);
    send_request(REQ_FINISH, 16'd0, 16'd0, 16'd0);

    // capacity above the list depth, coordinate extremes, widest range
    wait_for_results();
    load_settings(5'd31, DistMax);
    send_request(REQ_BEGIN, 16'h8000, 16'h8000, 16'hFFFF);
    send_request(REQ_OFFER, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_request(REQ_OFFER, 16'h7FFF, 16'h8000, 16'h8000);
    send_request(REQ_OFFER, 16'h8000, 16'h7FFF, 16'h1234);
    send_request(REQ_OFFER, 16'h8000, 16'h8000, 16'hFFFF);
    send_request(REQ_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // capacity zero keeps nothing
    wait_for_results();
    load_settings(5'd0, 33'd1000);
    send_request(REQ_BEGIN, 16'd100, -16'sd100, 16'd9);
    send_request(REQ_OFFER, 16'd100, -16'sd100, 16'd10);
    send_request(REQ_FINISH, 16'd0, 16'd0, 16'd0);

    // capacity one: range follows the single kept entry
    wait_for_results();
    load_settings(5'd1, 33'd50);
    send_request(REQ_BEGIN, 16'd0, 16'd0, 16'd0);
    send_request(REQ_OFFER, 16'd5, 16'd5, 16'd1);
    send_request(REQ_OFFER, 16'd1, 16'd1, 16'd2);
    send_request(REQ_OFFER, 16'd1, 16'd0, 16'd3);
    send_request(REQ_FINISH, 16'd0, 16'd0, 16'd0);

    // random phases: new settings, maybe continue the open query, then fresh queries
    phase = 0;
    while (requests_sent < ItemTarget) begin
      wait_for_results();
      idle_on = (requests_sent < QuietItems) && ($urandom_range(0, 3) != 0);
      load_settings(pick_capacity(), pick_range());
      // sender keeps offering while the receiver holds off, so the input stalls
      if (phase == 1) hold_long = 1'b1;
      if (phase != 0 && $urandom_range(0, 1) == 0) begin
        offer_burst($urandom_range(1, 12), 60);
        send_request(REQ_FINISH, CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
      end
      repeat ($urandom_range(2, 5)) run_query();
      phase++;
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/knni_pkg.sv
hw/rtl/knni_dist_sq.sv
hw/rtl/k_nearest_neighbour_insert.sv
test/knn_list_checker.sv
test/k_nearest_neighbour_insert_tb.sv
